@@ rtl/core/mktd_pkg.sv @@
package mktd_pkg;

    // Pattern buffer depth in elements and width of the tick counter.
    localparam int MAX_ELEMENTS = 16;
    localparam int COUNT_WIDTH  = 16;

    // Derived widths.
    localparam int LEN_W = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int REG_W = 16;
    localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
    localparam int CFG_IDX_W = 2;

    // Character table: code, element count, shape (element i at bit i, 1 is a dah).
    localparam int ROM_SIZE  = 68;
    localparam int ROM_LEN_W = 3;
    localparam int ROM_SHP_W = 7;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_CHAR     = 3'd1,
        EV_UNKNOWN  = 3'd2,
        EV_OVERFLOW = 3'd3,
        EV_SPACE    = 3'd4,
        EV_LINE     = 3'd5
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIT_LIMIT = 2'd0,
        CFG_CHAR_GAP  = 2'd1,
        CFG_WORD_GAP  = 2'd2,
        CFG_IDLE      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [REG_W-1:0] dit_limit;
        logic [REG_W-1:0] char_gap_start;
        logic [REG_W-1:0] word_gap_start;
        logic [REG_W-1:0] idle_start;
    } t_cfg;

    typedef struct packed {
        logic                    line_high;
        logic [COUNT_WIDTH-1:0]  tick_count;
        logic [1:0]              gap_level;
        logic [MAX_ELEMENTS-1:0] pattern_bits;
        logic [LEN_W-1:0]        pattern_length;
        logic [2:0]              pause_count;
        logic                    space_sent;
    } t_state;

    typedef struct packed {
        logic       tone_on;
        t_event     event_kind;
        logic [7:0] char_code;
    } t_result;

    localparam t_state STATE_RESET = '0;

    localparam logic [7+ROM_LEN_W+ROM_SHP_W:0] ROM [ROM_SIZE] = '{
        {8'h41, 3'd2, 7'd2},  {8'h42, 3'd4, 7'd1},  {8'h43, 3'd4, 7'd5},
        {8'h44, 3'd3, 7'd1},  {8'h45, 3'd1, 7'd0},  {8'h46, 3'd4, 7'd4},
        {8'h47, 3'd3, 7'd3},  {8'h48, 3'd4, 7'd0},  {8'h49, 3'd2, 7'd0},
        {8'h4A, 3'd4, 7'd14}, {8'h4B, 3'd3, 7'd5},  {8'h4C, 3'd4, 7'd2},
        {8'h4D, 3'd2, 7'd3},  {8'h4E, 3'd2, 7'd1},  {8'h4F, 3'd3, 7'd7},
        {8'h50, 3'd4, 7'd6},  {8'h51, 3'd4, 7'd11}, {8'h52, 3'd3, 7'd2},
        {8'h53, 3'd3, 7'd0},  {8'h54, 3'd1, 7'd1},  {8'h55, 3'd3, 7'd4},
        {8'h56, 3'd4, 7'd8},  {8'h57, 3'd3, 7'd6},  {8'h58, 3'd4, 7'd9},
        {8'h59, 3'd4, 7'd13}, {8'h5A, 3'd4, 7'd3},
        {8'h30, 3'd5, 7'd31}, {8'h31, 3'd5, 7'd30}, {8'h32, 3'd5, 7'd28},
        {8'h33, 3'd5, 7'd24}, {8'h34, 3'd5, 7'd16}, {8'h35, 3'd5, 7'd0},
        {8'h36, 3'd5, 7'd1},  {8'h37, 3'd5, 7'd3},  {8'h38, 3'd5, 7'd7},
        {8'h39, 3'd5, 7'd15},
        {8'h22, 3'd6, 7'd18}, {8'h27, 3'd6, 7'd30}, {8'h24, 3'd7, 7'd72},
        {8'h28, 3'd5, 7'd13}, {8'h29, 3'd6, 7'd45}, {8'h2B, 3'd5, 7'd10},
        {8'h2C, 3'd6, 7'd51}, {8'h2D, 3'd6, 7'd33}, {8'h2E, 3'd6, 7'd42},
        {8'h2F, 3'd5, 7'd9},  {8'h3A, 3'd6, 7'd7},  {8'h3B, 3'd6, 7'd21},
        {8'h3D, 3'd5, 7'd17}, {8'h3F, 3'd6, 7'd12}, {8'h5F, 3'd6, 7'd44},
        {8'h40, 3'd6, 7'd22}, {8'h3C, 3'd6, 7'd40}, {8'h3E, 3'd7, 7'd81},
        {8'h21, 3'd5, 7'd8},  {8'h26, 3'd5, 7'd2},  {8'h2A, 3'd5, 7'd10},
        {8'h65, 3'd7, 7'd0},
        {8'hDC, 3'd4, 7'd12}, {8'hC4, 3'd4, 7'd10}, {8'hC7, 3'd5, 7'd5},
        {8'hD6, 3'd4, 7'd7},  {8'hC9, 3'd5, 7'd4},  {8'hC8, 3'd5, 7'd18},
        {8'hC0, 3'd5, 7'd22}, {8'hD1, 3'd5, 7'd27}, {8'hAA, 3'd4, 7'd15},
        {8'hAE, 3'd5, 7'd19}
    };

endpackage

@@ rtl/core/mktd_ram.sv @@
module mktd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when the same entry is written at the same edge.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/mktd_next.sv @@
module mktd_next
    import mktd_pkg::*;
(
    input  t_state  i_state,
    input  logic    i_key,
    input  t_cfg    i_cfg,
    output t_state  o_state,
    output t_result o_res
);

    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    logic                        hit;
    logic [7:0]                  hit_code;
    logic [CMP_W-1:0]            tick_ext;
    logic                        below_dit;
    logic                        below_char;
    logic                        below_word;
    logic                        below_idle;

    // Priority search of the character table; the lowest entry wins.
    always_comb begin
        hit      = 1'b0;
        hit_code = '0;
        for (int i = ROM_SIZE - 1; i >= 0; i--) begin
            if (i_state.pattern_length == LEN_W'(ROM[i][ROM_LEN_W+ROM_SHP_W-1:ROM_SHP_W]) &&
                i_state.pattern_bits == MAX_ELEMENTS'(ROM[i][ROM_SHP_W-1:0])) begin
                hit      = 1'b1;
                hit_code = ROM[i][7+ROM_LEN_W+ROM_SHP_W:ROM_LEN_W+ROM_SHP_W];
            end
        end
    end

    assign tick_ext   = CMP_W'(i_state.tick_count);
    assign below_dit  = tick_ext < CMP_W'(i_cfg.dit_limit);
    assign below_char = tick_ext < CMP_W'(i_cfg.char_gap_start);
    assign below_word = tick_ext < CMP_W'(i_cfg.word_gap_start);
    assign below_idle = tick_ext < CMP_W'(i_cfg.idle_start);

    always_comb begin
        t_state     s;
        t_event     ev;
        logic [7:0] code;
        logic       do_pause;
        logic       three;

        s        = i_state;
        ev       = EV_NONE;
        code     = '0;
        do_pause = 1'b0;
        three    = 1'b0;

        if (i_state.line_high) begin
            if (!i_key) begin
                s.pause_count = '0;
                s.space_sent  = 1'b0;
                if (i_state.pattern_length >= LEN_W'(MAX_ELEMENTS)) begin
                    s.pattern_length = '0;
                    s.pattern_bits   = '0;
                    ev               = EV_OVERFLOW;
                end else begin
                    s.pattern_bits = i_state.pattern_bits |
                        (MAX_ELEMENTS'(!below_dit) << i_state.pattern_length[IDX_W-1:0]);
                    s.pattern_length = LEN_W'(i_state.pattern_length + 1'b1);
                end
                s.line_high  = 1'b0;
                s.tick_count = '0;
            end
        end else if (i_key) begin
            if (i_state.gap_level == 2'd3) begin
                ev = EV_LINE;
            end
            s.tick_count = '0;
            s.gap_level  = '0;
            s.line_high  = 1'b1;
        end else if (below_char) begin
            s = i_state;
        end else if (below_word) begin
            if (i_state.gap_level == 2'd0) begin
                do_pause    = 1'b1;
                s.gap_level = 2'd1;
            end
        end else if (below_idle) begin
            if (i_state.gap_level < 2'd2) begin
                do_pause    = 1'b1;
                three       = 1'b1;
                s.gap_level = 2'd2;
            end
        end else begin
            s.gap_level = 2'd3;
        end

        // A word gap counts as three pauses in a row.
        for (int k = 0; k < 3; k++) begin
            if (do_pause && (k == 0 || three) && !s.space_sent) begin
                if (s.pause_count == 3'd0) begin
                    ev               = hit ? EV_CHAR : EV_UNKNOWN;
                    code             = hit_code;
                    s.pattern_bits   = '0;
                    s.pattern_length = '0;
                end
                if (s.pause_count < 3'd4) begin
                    s.pause_count = s.pause_count + 3'd1;
                end
                if (s.pause_count > 3'd3) begin
                    ev           = EV_SPACE;
                    s.space_sent = 1'b1;
                end
            end
        end

        if (s.tick_count < CMAX) begin
            s.tick_count = s.tick_count + 1'b1;
        end

        o_state          = s;
        o_res.tone_on    = s.line_high;
        o_res.event_kind = ev;
        o_res.char_code  = (ev == EV_CHAR) ? code : 8'd0;
    end

endmodule

@@ rtl/core/morse_key_timing_decoder.sv @@
// A word accepted at the input passes through the decode stage and then the output register.
// Throughput: one word per cycle while the output is not stalled; either side may idle or stall at will.
// The decoder state lives in a one-entry RAM read at accept and written as the word
// leaves the decode stage; a bypass register covers a write and read at the same edge.
// Reset (synchronous, active low) empties the pipeline, restores the timing registers
// to their defaults and marks the state RAM unwritten, so it reads as all zeros.
module morse_key_timing_decoder
    import mktd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_key_level,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_tone_on,
    output logic [2:0]           o_event_kind,
    output logic [7:0]           o_char_code,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data
);

    localparam int STATE_W     = $bits(t_state);
    localparam int STATE_DEPTH = 1;
    localparam int STATE_AW    = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;
    localparam logic [STATE_AW-1:0] STATE_ADDR = '0;

    // Timing registers; the user must write them only while the decoder is idle, which the block leaves unenforced.
    t_cfg r_cfg;

    // Decode stage: the word whose state read is in flight or completed.
    logic   r_a_valid;
    logic   r_a_key;

    // The state RAM holds nothing useful until the first write after reset.
    logic   r_st_valid;
    logic   r_rd_init;

    // Bypass: the state written at the same edge as the read was issued.
    logic   r_byp_valid;
    t_state r_byp_state;

    // Output register.
    logic    r_out_valid;
    t_result r_out;

    logic             in_fire;
    logic             a_adv;
    logic             a_fire;
    logic [STATE_W-1:0] ram_rdata;
    t_state           cur_state;
    t_state           n_state;
    t_result          n_res;

    // The decode stage moves on whenever the output register is free or being emptied.
    assign a_adv   = !r_out_valid || !i_stall;
    assign a_fire  = r_a_valid && a_adv;
    assign o_stall = r_a_valid && !a_adv;
    assign in_fire = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dit_limit      <= REG_W'(9);
            r_cfg.char_gap_start <= REG_W'(9);
            r_cfg.word_gap_start <= REG_W'(23);
            r_cfg.idle_start     <= REG_W'(105);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DIT_LIMIT: r_cfg.dit_limit      <= i_cfg_data;
                CFG_CHAR_GAP:  r_cfg.char_gap_start <= i_cfg_data;
                CFG_WORD_GAP:  r_cfg.word_gap_start <= i_cfg_data;
                CFG_IDLE:      r_cfg.idle_start     <= i_cfg_data;
            endcase
        end
    end

    mktd_ram #(
        .WIDTH (STATE_W),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (a_fire),
        .i_waddr (STATE_ADDR),
        .i_wdata (n_state),
        .i_re    (in_fire),
        .i_raddr (STATE_ADDR),
        .o_rdata (ram_rdata)
    );

    // Pick the newest copy of the state: bypass, RAM, or the reset value.
    always_comb begin
        if (r_byp_valid) begin
            cur_state = r_byp_state;
        end else if (r_rd_init) begin
            cur_state = t_state'(ram_rdata);
        end else begin
            cur_state = STATE_RESET;
        end
    end

    mktd_next u_next (
        .i_state (cur_state),
        .i_key   (r_a_key),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_st_valid  <= 1'b0;
            r_rd_init   <= 1'b0;
            r_byp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_a_valid   <= 1'b1;
                // A read issued at the edge of a write sees the old entry.
                r_byp_valid <= a_fire;
                r_rd_init   <= r_st_valid;
            end else if (a_fire) begin
                r_a_valid <= 1'b0;
            end
            if (a_fire) begin
                r_st_valid  <= 1'b1;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_key     <= i_key_level;
            r_byp_state <= n_state;
        end
        if (a_fire) begin
            r_out <= n_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_tone_on    = r_out.tone_on;
    assign o_event_kind = r_out.event_kind;
    assign o_char_code  = r_out.char_code;

    // Input backpressure only arises from a full, stalled output register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall))
        else $error("input stalled without a stalled output");

    // Any state write leaves the RAM marked as holding live state.
    a_state_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_fire |=> r_st_valid)
        else $error("state RAM not marked written");

    // A character code is only carried by a character event.
    a_code_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind != EV_CHAR) |-> (o_char_code == 8'd0))
        else $error("character code on a non-character event");

    // A line break comes with the rising key edge, so the tone is on.
    a_line_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind == EV_LINE) |-> o_tone_on)
        else $error("line break without tone");

    // The buffered pattern never exceeds the buffer depth.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (cur_state.pattern_length <= LEN_W'(MAX_ELEMENTS)))
        else $error("pattern length beyond buffer depth");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import mktd_pkg::*;

    // Gap levels of the line while the key is up, in the order they are reached.
    typedef enum logic [1:0] {
        GAP_NONE,
        GAP_CHAR,
        GAP_WORD,
        GAP_IDLE
    } t_gap;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int GLYPHS         = 68;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_WORDS    = 16;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               i_key_level = 1'b0;
    logic               i_stall     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_DIT_LIMIT;
    logic [REG_W-1:0]   i_cfg_data  = '0;
    logic               o_stall;
    logic               o_valid;
    logic               o_tone_on;
    logic [2:0]         o_event_kind;
    logic [7:0]         o_char_code;

    morse_key_timing_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_key_level  (i_key_level),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tone_on    (o_tone_on),
        .o_event_kind (o_event_kind),
        .o_char_code  (o_char_code),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Character table kept in dot and dash notation, independent of the
    // encoded table in the package. The first matching entry wins.
    string glyph_shape [GLYPHS] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
        "---..", "----.",
        ".-..-.", ".----.", "...-..-", "-.--.", "-.--.-", ".-.-.", "--..--",
        "-....-", ".-.-.-", "-..-.", "---...", "-.-.-.", "-...-", "..--..",
        "..--.-", ".--.-.", "...-.-", "-...-.-", "...-.", ".-...", ".-.-.",
        ".......",
        "..--", ".-.-", "-.-..", "---.", "..-..", ".-..-", ".--.-", "--.--",
        "----", "--..-"
    };
    logic [7:0] glyph_code [GLYPHS] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
        8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
        8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h22, 8'h27, 8'h24, 8'h28, 8'h29, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
        8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h5F, 8'h40, 8'h3C, 8'h3E, 8'h21, 8'h26,
        8'h2A,
        8'h65,
        8'hDC, 8'hC4, 8'hC7, 8'hD6, 8'hC9, 8'hC8, 8'hC0, 8'hD1, 8'hAA, 8'hAE
    };

    // Timing registers as the decoder should hold them.
    logic [REG_W-1:0] dit_ticks;
    logic [REG_W-1:0] char_gap_ticks;
    logic [REG_W-1:0] word_gap_ticks;
    logic [REG_W-1:0] idle_ticks;

    // Decoder state as predicted here.
    logic                    key_down;
    logic [COUNT_WIDTH-1:0]  since_edge;
    t_gap                    gap_seen;
    logic [MAX_ELEMENTS-1:0] elem_bits;
    logic [LEN_W-1:0]        elem_count;
    logic [2:0]              pause_tally;
    logic                    space_done;

    // Results still owed by the decoder, oldest first.
    t_result tick_results_due [$];

    int error_count = 0;
    int words_sent  = 0;
    int burst_left  = 0;
    int quiet_cycles = 0;
    int stall_left  = 0;
    int stall_pct   = 0;

    function automatic int span(input int lo, input int hi);
        if (hi <= lo) return lo;
        return $urandom_range(hi, lo);
    endfunction

    function automatic void clear_decoder_state();
        key_down    = 1'b0;
        since_edge  = '0;
        gap_seen    = GAP_NONE;
        elem_bits   = '0;
        elem_count  = '0;
        pause_tally = '0;
        space_done  = 1'b0;
        dit_ticks      = 16'd9;
        char_gap_ticks = 16'd9;
        word_gap_ticks = 16'd23;
        idle_ticks     = 16'd105;
    endfunction

    // Search the table for the buffered pattern; an empty buffer never matches.
    function automatic logic match_glyph(output logic [7:0] code);
        string s;
        logic  same;
        code = '0;
        for (int i = 0; i < GLYPHS; i++) begin
            s = glyph_shape[i];
            if (s.len() == elem_count) begin
                same = 1'b1;
                for (int j = 0; j < s.len(); j++) begin
                    if ((s[j] == "-") != elem_bits[j]) same = 1'b0;
                end
                if (same) begin
                    code = glyph_code[i];
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic void append_element(input logic is_dah, inout t_event ev);
        pause_tally = '0;
        space_done  = 1'b0;
        if (elem_count >= MAX_ELEMENTS) begin
            // A full buffer drops the new element and starts over.
            elem_count = '0;
            elem_bits  = '0;
            ev = EV_OVERFLOW;
        end else begin
            if (is_dah) elem_bits[elem_count[IDX_W-1:0]] = 1'b1;
            elem_count++;
        end
    endfunction

    function automatic void close_pause(inout t_event ev, inout logic [7:0] code);
        logic [7:0] hit;
        if (space_done) return;
        if (pause_tally == 0) begin
            if (match_glyph(hit)) begin
                ev   = EV_CHAR;
                code = hit;
            end else begin
                ev = EV_UNKNOWN;
            end
            elem_bits  = '0;
            elem_count = '0;
        end
        if (pause_tally < 4) pause_tally++;
        if (pause_tally > 3) begin
            ev         = EV_SPACE;
            code       = '0;
            space_done = 1'b1;
        end
    endfunction

    // Advances the predicted state by one key sample and returns the word
    // the decoder must produce for it.
    function automatic t_result decode_tick(input logic key);
        t_result    res;
        t_event     ev;
        logic [7:0] code;
        ev   = EV_NONE;
        code = '0;
        if (key_down) begin
            if (!key) begin
                append_element(since_edge >= dit_ticks, ev);
                key_down   = 1'b0;
                since_edge = '0;
            end
        end else if (key) begin
            if (gap_seen == GAP_IDLE) ev = EV_LINE;
            since_edge = '0;
            gap_seen   = GAP_NONE;
            key_down   = 1'b1;
        end else if (since_edge < char_gap_ticks) begin
            // Still inside the gap between two elements.
        end else if (since_edge < word_gap_ticks) begin
            if (gap_seen < GAP_CHAR) begin
                close_pause(ev, code);
                gap_seen = GAP_CHAR;
            end
        end else if (since_edge < idle_ticks) begin
            if (gap_seen < GAP_WORD) begin
                for (int k = 0; k < 3; k++) close_pause(ev, code);
                gap_seen = GAP_WORD;
            end
        end else begin
            gap_seen = GAP_IDLE;
        end
        if (since_edge != '1) since_edge++;
        if (ev != EV_CHAR) code = '0;
        res.tone_on    = key_down;
        res.event_kind = ev;
        res.char_code  = code;
        return res;
    endfunction

    // Sends one key sample as a word, with random gaps between bursts.
    task automatic send_key(input logic level);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_valid     <= 1'b1;
        i_key_level <= level;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
        words_sent++;
        tick_results_due.push_back(decode_tick(level));
    endtask

    task automatic send_run(input logic level, input int n);
        repeat (n) send_key(level);
    endtask

    // Keys a pattern; marks and inner gaps take random lengths from the ranges.
    // The key is left down after the last element.
    task automatic send_shape(input string shape, input int dit_lo, input int dit_hi,
                              input int dah_lo, input int dah_hi,
                              input int gap_lo, input int gap_hi);
        for (int i = 0; i < shape.len(); i++) begin
            if (i > 0) send_run(1'b0, span(gap_lo, gap_hi));
            if (shape[i] == "-") send_run(1'b1, span(dah_lo, dah_hi));
            else send_run(1'b1, span(dit_lo, dit_hi));
        end
    endtask

    // Waits until every owed word has come back and the pipeline is empty.
    task automatic drain();
        i_valid <= 1'b0;
        while (tick_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [REG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic program_timing(input logic [REG_W-1:0] dit, input logic [REG_W-1:0] cgap,
                                  input logic [REG_W-1:0] wgap, input logic [REG_W-1:0] idl);
        drain();
        write_reg(CFG_DIT_LIMIT, dit);
        write_reg(CFG_CHAR_GAP, cgap);
        write_reg(CFG_WORD_GAP, wgap);
        write_reg(CFG_IDLE, idl);
        i_cfg_we <= 1'b0;
        dit_ticks      = dit;
        char_gap_ticks = cgap;
        word_gap_ticks = wgap;
        idle_ticks     = idl;
    endtask

    // Reset timing: an empty pattern at the first character gap, then E, a
    // word space, idle and a line break, then N with every length on its limit.
    task automatic test_default_timing();
        send_run(1'b0, 12);
        send_shape(".", 3, 3, 9, 9, 1, 1);
        send_run(1'b0, 110);
        send_shape("-.", 8, 8, 9, 9, 9, 9);
        send_run(1'b0, 10);
    endtask

    // Every kind of event at short timing: a character, a word space, a
    // line break, an unknown pattern, an overflow and an empty pattern.
    task automatic test_event_kinds();
        program_timing(16'd2, 16'd2, 16'd3, 16'd4);
        send_shape(".-", 1, 1, 2, 2, 1, 1);
        send_run(1'b0, 5);
        send_shape("........", 1, 1, 2, 2, 1, 2);
        send_run(1'b0, 3);
        send_shape(".................", 1, 1, 2, 2, 1, 1);
        send_run(1'b0, 6);
    endtask

    // Registers at their limits: every mark a dah, then every mark a dit.
    task automatic test_register_extremes();
        program_timing(16'd1, 16'd1, 16'hFFFF, 16'hFFFF);
        send_shape("..", 1, 1, 1, 1, 1, 1);
        send_run(1'b0, 3);
        program_timing(16'hFFFF, 16'd2, 16'd3, 16'd4);
        send_shape("-.", 1, 1, 3, 3, 1, 1);
        send_run(1'b0, 6);
    endtask

    // Registers out of order: a skipped character gap decodes at the word
    // gap without a space, and the count is never below a zero register.
    task automatic test_unordered_registers();
        program_timing(16'd0, 16'd6, 16'd3, 16'd9);
        send_shape("..", 1, 1, 1, 1, 2, 2);
        send_run(1'b0, 12);
        send_shape(".", 1, 1, 1, 1, 1, 1);
        send_run(1'b0, 4);
        program_timing(16'd3, 16'd0, 16'd4, 16'd7);
        send_shape("-..", 1, 2, 3, 4, 1, 1);
        send_run(1'b0, 9);
    endtask

    // Every third table entry from a random starting entry, at the shortest
    // timing that still keys each pattern cleanly; a long tail now and then
    // also gives a word space.
    task automatic test_glyph_table();
        int first;
        program_timing(16'd2, 16'd1, 16'd3, 16'd4);
        first = $urandom_range(0, 2);
        for (int g = first; g < GLYPHS; g += 3) begin
            send_shape(glyph_shape[g], 1, 1, 2, 3, 1, 1);
            send_run(1'b0, span(2, 4));
        end
    endtask

    // One random stretch of keying under the current registers: mostly
    // well-formed characters, now and then overlong patterns and noise.
    task automatic key_random_stretch();
        int    pick;
        int    d;
        int    c;
        int    w;
        int    idl;
        int    safe_gap;
        int    tail;
        string shape;
        d   = dit_ticks;
        c   = char_gap_ticks;
        w   = word_gap_ticks;
        idl = idle_ticks;
        safe_gap = (c < w) ? c : w;
        if (idl < safe_gap) safe_gap = idl;
        if (safe_gap < 1) safe_gap = 1;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            if (pick < 5) begin
                shape = glyph_shape[$urandom_range(0, GLYPHS - 1)];
            end else begin
                shape = "";
                repeat ((pick == 6) ? span(14, 19) : span(1, 8)) begin
                    if ($urandom_range(0, 1)) shape = {shape, "-"};
                    else shape = {shape, "."};
                end
            end
            send_shape(shape, 1, (d > 1) ? d - 1 : 1, (d > 0) ? d : 1, d + 2, 1, safe_gap);
            case ($urandom_range(0, 3))
                0: begin
                    tail = c + 1 + span(0, 1);
                end
                1: begin
                    tail = w + 1 + span(0, 2);
                end
                2: begin
                    tail = idl + 1 + span(0, 2);
                end
                default: begin
                    tail = span(1, idl + 2);
                end
            endcase
            send_run(1'b0, tail);
        end else if (pick < 9) begin
            repeat (span(1, 6)) send_key(1'($urandom_range(0, 1)));
        end else begin
            send_run(1'b1, span(1, d + 3));
        end
    endtask

    task automatic test_random_traffic();
        int phase_start;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    program_timing(16'd2, 16'd2, 16'd3, 16'd4);
                end
                1: begin
                    program_timing(16'd3, 16'd3, 16'd7, 16'd12);
                end
                2: begin
                    program_timing(16'd9, 16'd9, 16'd23, 16'd105);
                end
                3: begin
                    program_timing(16'd5, 16'd4, 16'd10, 16'd16);
                end
                4: begin
                    program_timing(16'd2, 16'd6, 16'd3, 16'd9);
                end
                5: begin
                    program_timing(16'd1, 16'd1, 16'd2, 16'd3);
                end
                default: begin
                    program_timing(16'd4, 16'd2, 16'd5, 16'd8);
                end
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) key_random_stretch();
        end
    endtask

    initial begin
        clear_decoder_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_timing();
        test_event_kinds();
        test_register_extremes();
        test_unordered_registers();
        test_glyph_table();
        test_random_traffic();
        drain();
        repeat (4) @(posedge i_clk);
        if (error_count == 0 && tick_results_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // The receiver stalls on its own schedule: stretches of a random stall
    // rate, some of them with no stalls at all.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(16, 96);
            case ($urandom_range(0, 4))
                0, 1: stall_pct = 0;
                2: stall_pct = 20;
                3: stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end else begin
            stall_left--;
        end
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Each word taken from the decoder is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (tick_results_due.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: word with nothing owed: tone %b event %0d code %h",
                             $time, o_tone_on, o_event_kind, o_char_code);
            end else begin
                want = tick_results_due.pop_front();
                if (o_tone_on !== want.tone_on || o_event_kind !== want.event_kind
                        || o_char_code !== want.char_code) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display(
                            "%0t: mismatch: tone %b/%b event %0d/%0d code %h/%h (exp/act)",
                            $time, want.tone_on, o_tone_on, want.event_kind, o_event_kind,
                            want.char_code, o_char_code);
                end
            end
        end
    end

    // Ends the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
